FILE: rtl/assert_macros.svh
// Assertion macros shared by the steering angle optimizer RTL.
// Depends on nothing; the including module provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while rst is high.
`define SSAO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define SSAO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ssao_pkg.sv
// Package for the steering angle optimizer: widths, angle constants,
// register codes and the configuration struct. Depends on nothing.
package ssao_pkg;

  localparam int ANGLE_W = 15;
  localparam int OUT_ANGLE_W = 17;
  localparam int ERR_W = 18;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int SPEED_WIDTH_DEFAULT = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic signed [ERR_W-1:0] DEG360 = ERR_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] DEG180 = ERR_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] DEG90 = ERR_W'(90 << ANGLE_FRAC_BITS);

  typedef enum logic {
    REG_ANGLE_OPT = 1'b0,
    REG_ARC_OPT   = 1'b1
  } ssao_reg_t;

  typedef struct packed {
    logic angle_opt_enable;
    logic arc_opt_enable;
  } ssao_cfg_t;

endpackage

FILE: rtl/ssao_cfg.sv
// APB register block holding the two optimization enables.
// Depends on ssao_pkg.
module ssao_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssao_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ssao_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ssao_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output ssao_pkg::ssao_cfg_t              cfg
);
  import ssao_pkg::*;

  ssao_reg_t reg_sel;
  logic      wr_en;

  assign reg_sel = ssao_reg_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_opt_enable <= 1'b1;
      cfg.arc_opt_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ANGLE_OPT: cfg.angle_opt_enable <= pwdata[0];
        REG_ARC_OPT:   cfg.arc_opt_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ANGLE_OPT: prdata[0] = cfg.angle_opt_enable;
      REG_ARC_OPT:   prdata[0] = cfg.arc_opt_enable;
      default: ;
    endcase
  end

endmodule

FILE: rtl/ssao_calc.sv
// Combinational angle optimization: error normalization, reversal choice,
// minor-arc wrap and drive negation. Depends on ssao_pkg.
module ssao_calc #(
  parameter int SPEED_WIDTH = ssao_pkg::SPEED_WIDTH_DEFAULT
) (
  input  logic [ssao_pkg::ANGLE_W-1:0]            goal_angle,
  input  logic [ssao_pkg::ANGLE_W-1:0]            current_angle,
  input  logic signed [SPEED_WIDTH-1:0]           target_speed,
  input  logic                                    rev_in,
  input  ssao_pkg::ssao_cfg_t                     cfg,
  output logic signed [ssao_pkg::OUT_ANGLE_W-1:0] steer_command,
  output logic signed [ssao_pkg::OUT_ANGLE_W-1:0] angle_error,
  output logic signed [SPEED_WIDTH-1:0]           drive_command,
  output logic                                    rev_out
);
  import ssao_pkg::*;

  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = {1'b0, {(SPEED_WIDTH-1){1'b1}}};

  logic signed [ERR_W-1:0] tgt;
  logic signed [ERR_W-1:0] cur;
  logic signed [ERR_W-1:0] diff;
  logic signed [ERR_W-1:0] err0;
  logic signed [ERR_W-1:0] err1;
  logic signed [ERR_W-1:0] err2;
  logic signed [ERR_W-1:0] err3;
  logic signed [ERR_W-1:0] alt;
  logic signed [ERR_W-1:0] shortest;
  logic signed [ERR_W-1:0] err_redo;
  logic signed [ERR_W-1:0] err_sel;
  logic signed [ERR_W-1:0] err_fin;
  logic signed [ERR_W-1:0] steer_full;
  logic                    flip;

  assign tgt = signed'({{(ERR_W-ANGLE_W){1'b0}}, goal_angle});
  assign cur = signed'({{(ERR_W-ANGLE_W){1'b0}}, current_angle});
  assign diff = tgt - cur;
  assign err0 = rev_in ? diff - DEG180 : diff;
  assign err1 = (err0 > DEG360) ? err0 - DEG360 : err0;
  assign err2 = (err1 < 0) ? err1 + DEG360 : err1;
  assign err3 = (err2 < 0) ? err2 + DEG360 : err2;
  assign alt = DEG360 - err3;
  assign shortest = (err3 < alt) ? err3 : alt;
  assign flip = shortest > DEG90;
  assign rev_out = cfg.angle_opt_enable ? (rev_in ^ flip) : rev_in;
  assign err_redo = rev_out ? diff - DEG180 : diff;

  always_comb begin
    if (!cfg.angle_opt_enable) begin
      err_sel = diff;
    end else if (flip) begin
      err_sel = err_redo;
    end else begin
      err_sel = err3;
    end
    priority if (cfg.arc_opt_enable && err_sel > DEG180) begin
      err_fin = err_sel - DEG360;
    end else if (cfg.arc_opt_enable && err_sel < -DEG180) begin
      err_fin = err_sel + DEG360;
    end else begin
      err_fin = err_sel;
    end
  end

  assign steer_full = cur + err_fin;
  assign steer_command = steer_full[OUT_ANGLE_W-1:0];
  assign angle_error = err_fin[OUT_ANGLE_W-1:0];

  always_comb begin
    if (!rev_out) begin
      drive_command = target_speed;
    end else if (target_speed == SPEED_MIN) begin
      drive_command = SPEED_MAX;
    end else begin
      drive_command = -target_speed;
    end
  end

endmodule

FILE: rtl/swerve_steer_angle_optimizer.sv
// An accepted item is held in the input register, then loaded into the result
// register, which offers it. Throughput: one item per cycle unless m_tready stalls;
// an input register and a result register bracket a single combinational pass
// through ssao_calc.
// The reversed flag and both enables are set by the synchronous active-high rst:
// flag clear, both optimizations enabled. Results wait in the output register.
module swerve_steer_angle_optimizer #(
  parameter int SPEED_WIDTH = ssao_pkg::SPEED_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ssao_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [ssao_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ssao_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // goal_angle, current_angle, target_speed, zero pad
  input  logic [((2*ssao_pkg::ANGLE_W+SPEED_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // steer_command, angle_error, drive_command, reversed, zero pad
  output logic [((2*ssao_pkg::OUT_ANGLE_W+SPEED_WIDTH+1+7)/8)*8-1:0] m_tdata
);
  import ssao_pkg::*;
  `include "assert_macros.svh"

  localparam int IN_USED = 2*ANGLE_W + SPEED_WIDTH;
  localparam int OUT_USED = 2*OUT_ANGLE_W + SPEED_WIDTH + 1;
  localparam int OUT_W = ((OUT_USED + 7) / 8) * 8;

  ssao_cfg_t cfg;

  logic                          in_valid;
  logic [ANGLE_W-1:0]            in_target;
  logic [ANGLE_W-1:0]            in_current;
  logic signed [SPEED_WIDTH-1:0] in_speed;
  logic                          wheel_reversed;
  logic                          rev_next;
  logic                          move;
  logic                          out_valid;
  logic [OUT_W-1:0]              out_data;

  logic signed [OUT_ANGLE_W-1:0] c_steer;
  logic signed [OUT_ANGLE_W-1:0] c_error;
  logic signed [SPEED_WIDTH-1:0] c_drive;

  ssao_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssao_calc #(.SPEED_WIDTH(SPEED_WIDTH)) u_calc (
    .goal_angle    (in_target),
    .current_angle (in_current),
    .target_speed  (in_speed),
    .rev_in        (wheel_reversed),
    .cfg           (cfg),
    .steer_command (c_steer),
    .angle_error   (c_error),
    .drive_command (c_drive),
    .rev_out       (rev_next)
  );

  assign move = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || move;
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
      wheel_reversed <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
        wheel_reversed <= rev_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_target <= s_tdata[ANGLE_W-1:0];
      in_current <= s_tdata[2*ANGLE_W-1:ANGLE_W];
      in_speed <= s_tdata[IN_USED-1:2*ANGLE_W];
    end
    if (move) begin
      out_data <= {{(OUT_W-OUT_USED){1'b0}}, rev_next, c_drive, c_error, c_steer};
    end
  end

  `SSAO_ASSERT(a_move_loads_out, move |=> out_valid, "result register not loaded")
  `SSAO_ASSERT(a_flag_only_on_move, !move |=> $stable(wheel_reversed), "flag changed idle")
  `SSAO_ASSERT(a_flag_matches_out, out_valid |-> out_data[OUT_USED-1] == wheel_reversed,
               "result flag differs from state")
  `SSAO_ASSERT(a_no_toggle_when_off,
               (move && !cfg.angle_opt_enable) |=> wheel_reversed == $past(wheel_reversed),
               "flag toggled with angle optimization off")
  `SSAO_ASSERT(a_stall_reason, (in_valid && !s_tready) |-> (out_valid && !m_tready),
               "input stalled without output backpressure")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for swerve_steer_angle_optimizer: random and directed steering items,
// a built-in model of the reversal and arc choice, APB register changes between phases.
// Depends on ssao_pkg and the swerve_steer_angle_optimizer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssao_pkg::*;

  localparam int SPEED_W = SPEED_WIDTH_DEFAULT;
  localparam int IN_W = ((2*ANGLE_W + SPEED_W + 7)/8)*8;
  localparam int OUT_W = ((2*OUT_ANGLE_W + SPEED_W + 1 + 7)/8)*8;
  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
  localparam int SPEED_MAX = (1 << (SPEED_W-1)) - 1;
  localparam int ANGLE_ALL = (1 << ANGLE_W) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 240;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed;
    logic [ANGLE_W-1:0]        current_angle;
    logic [ANGLE_W-1:0]        goal_angle;
  } steer_item_t;

  typedef struct packed {
    logic                          reversed;
    logic signed [SPEED_W-1:0]     drive_command;
    logic signed [OUT_ANGLE_W-1:0] angle_error;
    logic signed [OUT_ANGLE_W-1:0] steer_command;
  } steer_result_t;

  typedef struct {
    steer_item_t item;
    bit          drain_first;
  } steer_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // goal_angle, current_angle, target_speed, zero pad
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // steer_command, angle_error, drive_command, reversed, zero pad
  logic [OUT_W-1:0] m_tdata;

  steer_request_t steer_requests[$];
  steer_result_t  expected_commands[$];
  steer_item_t    item_on_bus;

  bit wheel_flipped = 1'b0;
  bit cfg_angle_opt = 1'b1;
  bit cfg_arc_opt = 1'b1;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;
  int results_checked = 0;
  int reversed_seen = 0;
  int quiet_cycles = 0;

  swerve_steer_angle_optimizer uut (.*);

  always #5 clk = ~clk;

  function automatic steer_result_t predict_steering(input steer_item_t it);
    int tgt, cur, spd, err, shortest, drive;
    steer_result_t r;
    tgt = int'(it.goal_angle);
    cur = int'(it.current_angle);
    spd = int'(it.target_speed);
    if (cfg_angle_opt) begin
      err = tgt - cur - (wheel_flipped ? HALF_TURN : 0);
      if (err > FULL_TURN) err -= FULL_TURN;
      if (err < 0) err += FULL_TURN;
      if (err < 0) err += FULL_TURN;
      shortest = (err < FULL_TURN - err) ? err : FULL_TURN - err;
      if (shortest > QUARTER_TURN) begin
        wheel_flipped = !wheel_flipped;
        err = tgt - cur - (wheel_flipped ? HALF_TURN : 0);
      end
    end else begin
      err = tgt - cur;
    end
    if (cfg_arc_opt) begin
      if (err > HALF_TURN) err -= FULL_TURN;
      else if (err < -HALF_TURN) err += FULL_TURN;
    end
    drive = wheel_flipped ? -spd : spd;
    if (drive > SPEED_MAX) drive = SPEED_MAX;
    r.steer_command = OUT_ANGLE_W'(cur + err);
    r.angle_error = OUT_ANGLE_W'(err);
    r.drive_command = SPEED_W'(drive);
    r.reversed = wheel_flipped;
    return r;
  endfunction

  task automatic flag_error(input string field, input int got, input int want);
    error_count++;
    $display("ERROR %0t: %s got %0d, expected %0d", $time, field, got, want);
  endtask

  always @(posedge clk) begin : drive_items
    bit busy;
    bit launch;
    steer_request_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_commands.push_back(predict_steering(item_on_bus));
        busy = 1'b0;
      end
      if (!busy) begin
        launch = 1'b0;
        if (steer_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          if (!steer_requests[0].drain_first || expected_commands.size() == 0) launch = 1'b1;
        end
        if (launch) begin
          req = steer_requests.pop_front();
          item_on_bus = req.item;
          s_tdata <= IN_W'(item_on_bus);
        end
        s_tvalid <= launch;
      end
    end
  end

  always @(posedge clk) begin : check_results
    steer_result_t got;
    steer_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = steer_result_t'(m_tdata[$bits(steer_result_t)-1:0]);
        if (expected_commands.size() == 0) begin
          flag_error("unexpected result, steer_command", int'(got.steer_command), 0);
        end else begin
          want = expected_commands.pop_front();
          if (got.steer_command !== want.steer_command)
            flag_error("steer_command", int'(got.steer_command), int'(want.steer_command));
          if (got.angle_error !== want.angle_error)
            flag_error("angle_error", int'(got.angle_error), int'(want.angle_error));
          if (got.drive_command !== want.drive_command)
            flag_error("drive_command", int'(got.drive_command), int'(want.drive_command));
          if (got.reversed !== want.reversed)
            flag_error("reversed", int'(got.reversed), int'(want.reversed));
          results_checked++;
          if (want.reversed) reversed_seen++;
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pwrite)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("swerve_steer_angle_optimizer: mismatch");
          $finish;
        end
      end
    end
  end

  task automatic add_request(input int tgt, input int cur, input int spd, input bit drain = 1'b0);
    steer_request_t req;
    req.item.goal_angle = ANGLE_W'(tgt);
    req.item.current_angle = ANGLE_W'(cur);
    req.item.target_speed = SPEED_W'(spd);
    req.drain_first = drain;
    steer_requests.push_back(req);
  endtask

  // Most targets cluster around quarter-turn offsets from the current angle so that
  // the reversal and wrap thresholds are crossed from both sides.
  task automatic add_random_requests(input int count);
    int tgt, cur, off, spd, pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      cur = $urandom_range(FULL_TURN);
      if (pick < 5) begin
        cur = $urandom_range(ANGLE_ALL);
        tgt = $urandom_range(ANGLE_ALL);
      end else if (pick < 45) begin
        tgt = $urandom_range(FULL_TURN - 1);
      end else begin
        off = QUARTER_TURN * int'($urandom_range(4)) + int'($urandom_range(4)) - 2;
        if ($urandom_range(1)) off = -off;
        tgt = cur + off;
        while (tgt < 0) tgt += FULL_TURN;
        while (tgt >= FULL_TURN) tgt -= FULL_TURN;
      end
      case ($urandom_range(9))
        0: spd = -SPEED_MAX - 1;
        1: spd = SPEED_MAX;
        2: spd = int'($urandom_range(8)) - 4;
        default: spd = int'($urandom_range(2*SPEED_MAX + 1)) - SPEED_MAX - 1;
      endcase
      add_request(tgt, cur, spd, i == count/2);
    end
  endtask

  task automatic apb_write(input ssao_reg_t idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_ANGLE_OPT) cfg_angle_opt = value[0];
    else cfg_arc_opt = value[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (steer_requests.size() != 0 || s_tvalid || expected_commands.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run_test
    int angle_tbl[5] = '{1, 0, 1, 0, 1};
    int arc_tbl[5] = '{1, 1, 0, 0, 1};
    int tx_tbl[5] = '{20, 53, 53, 0, 0};
    int rx_tbl[5] = '{53, 20, 20, 0, 0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 53;
    add_request(0, 0, 0);
    add_request(FULL_TURN - 1, 0, SPEED_MAX);
    add_request(0, FULL_TURN, -SPEED_MAX - 1);
    add_request(QUARTER_TURN, 0, 1);
    add_request(QUARTER_TURN + 1, 0, -SPEED_MAX - 1);
    add_request(0, 0, 100);
    add_request(FULL_TURN, 0, -1);
    add_request(FULL_TURN - QUARTER_TURN, 0, -2);
    add_request(FULL_TURN - QUARTER_TURN - 1, 0, 3);
    add_request(ANGLE_ALL, 0, -SPEED_MAX - 1);
    add_request(0, ANGLE_ALL, 12345);
    add_request(ANGLE_ALL, ANGLE_ALL, -1);
    add_request(HALF_TURN, HALF_TURN, 0);
    wait_idle();
    for (int p = 0; p < 5; p++) begin
      tx_idle_pct = tx_tbl[p];
      rx_idle_pct = rx_tbl[p];
      apb_write(REG_ANGLE_OPT, ($urandom() & ~32'h1) | APB_DATA_W'(angle_tbl[p]));
      apb_write(REG_ARC_OPT, ($urandom() & ~32'h1) | APB_DATA_W'(arc_tbl[p]));
      if (p == 1) begin
        // The minor-arc edges are only reachable with reversal choice off.
        add_request(HALF_TURN, 0, 1);
        add_request(0, HALF_TURN, -1);
        add_request(HALF_TURN + 1, 0, 5);
        add_request(0, HALF_TURN + 1, -5);
        add_request(0, FULL_TURN, 7);
        add_request(FULL_TURN - 1, 0, 9);
      end
      if (p == 3) begin
        add_request(0, FULL_TURN, -SPEED_MAX - 1);
        add_request(ANGLE_ALL, 0, SPEED_MAX);
        add_request(0, ANGLE_ALL, 1);
      end
      add_random_requests(RANDOM_PER_PHASE);
      wait_idle();
    end
    $display("Checked %0d steering results over six phases and all four enable pairs, %0d reversed.",
             results_checked, reversed_seen);
    $display("Both enables were toggled, with stalls on either side and a drained pause.");
    if (error_count == 0) begin
      $display("swerve_steer_angle_optimizer: match");
    end else begin
      $display("swerve_steer_angle_optimizer: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ssao_pkg.sv
rtl/ssao_cfg.sv
rtl/ssao_calc.sv
rtl/swerve_steer_angle_optimizer.sv
dv/testbench.sv
